>>> sv/printf_format_spec_parser_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the format spec parser
// Clocked implication checks with asynchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef PRINTF_FORMAT_SPEC_PARSER_ASSERT_SVH
`define PRINTF_FORMAT_SPEC_PARSER_ASSERT_SVH

// same-cycle implication
`define FSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsp assertion failed");

// next-cycle implication
`define FSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsp assertion failed");

`endif

>>> sv/fsp_pkg.sv
// ---------------------------------------------------------------------------
// fsp_pkg
// Shared constants, codes and types of the format spec parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsp_pkg;

    localparam int unsigned COUNT_BITS_DEF    = 16;
    localparam int unsigned POINTER_BYTES_DEF = 8;

    // config register indexes
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLOAT_EN  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_LONG = 1'd1;

    // parse phases
    localparam logic [2:0] PH_FLAGS      = 3'd0;
    localparam logic [2:0] PH_WIDTH      = 3'd1;
    localparam logic [2:0] PH_PREC_START = 3'd2;
    localparam logic [2:0] PH_PREC_DIG   = 3'd3;
    localparam logic [2:0] PH_AFTER_L    = 3'd4;
    localparam logic [2:0] PH_AFTER_H    = 3'd5;
    localparam logic [2:0] PH_TYPE       = 3'd6;
    localparam logic [2:0] PH_UNUSED     = 3'd7;

    // conversion kinds
    localparam logic [3:0] KIND_NONE    = 4'd0;
    localparam logic [3:0] KIND_INT     = 4'd1;
    localparam logic [3:0] KIND_UINT    = 4'd2;
    localparam logic [3:0] KIND_FLOAT   = 4'd3;
    localparam logic [3:0] KIND_EXP     = 4'd4;
    localparam logic [3:0] KIND_CHAR    = 4'd5;
    localparam logic [3:0] KIND_STR     = 4'd6;
    localparam logic [3:0] KIND_PTR     = 4'd7;
    localparam logic [3:0] KIND_PERCENT = 4'd8;

    // radix values
    localparam logic [4:0] RADIX_NONE = 5'd0;
    localparam logic [4:0] RADIX_BIN  = 5'd2;
    localparam logic [4:0] RADIX_OCT  = 5'd8;
    localparam logic [4:0] RADIX_DEC  = 5'd10;
    localparam logic [4:0] RADIX_HEX  = 5'd16;

    // length modifiers
    localparam logic [2:0] LEN_NONE   = 3'd0;
    localparam logic [2:0] LEN_H      = 3'd1;
    localparam logic [2:0] LEN_HH     = 3'd2;
    localparam logic [2:0] LEN_L      = 3'd3;
    localparam logic [2:0] LEN_LL     = 3'd4;
    localparam logic [2:0] LEN_LLONLY = 3'd5;

    // flag bit positions
    localparam int unsigned FB_LEFT  = 0;
    localparam int unsigned FB_ZERO  = 1;
    localparam int unsigned FB_PLUS  = 2;
    localparam int unsigned FB_SPACE = 3;
    localparam int unsigned FB_HASH  = 4;
    localparam int unsigned FB_PREC  = 5;
    localparam int unsigned FB_UPPER = 6;
    localparam int unsigned FB_ADAPT = 7;

    // parse state other than the counters
    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] flags;
        logic [1:0] stars;
        logic [2:0] length;
    } fsp_state_t;

    typedef struct packed {
        logic [3:0]  spec_kind;
        logic [4:0]  radix;
        logic [15:0] field_width;
        logic [15:0] digits_wanted;
        logic        width_from_arg;
        logic        precision_from_arg;
        logic [7:0]  flag_bits;
        logic [2:0]  length_code;
        logic        end_consumed;
    } fsp_result_t;

endpackage

>>> sv/fsp_char_if.sv
// ---------------------------------------------------------------------------
// fsp_char_if
// Character channel: one format character per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

>>> sv/fsp_spec_if.sv
// ---------------------------------------------------------------------------
// fsp_spec_if
// Result channel: one parsed conversion spec per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsp_spec_if;
    logic        valid;
    logic        ready;
    logic [3:0]  spec_kind;
    logic [4:0]  radix;
    logic [15:0] field_width;
    logic [15:0] digits_wanted;
    logic        width_from_arg;
    logic        precision_from_arg;
    logic [7:0]  flag_bits;
    logic [2:0]  length_code;
    logic        end_consumed;

    modport source (
        output valid, output spec_kind, output radix, output field_width,
        output digits_wanted, output width_from_arg, output precision_from_arg,
        output flag_bits, output length_code, output end_consumed,
        input ready
    );
    modport sink (
        input valid, input spec_kind, input radix, input field_width,
        input digits_wanted, input width_from_arg, input precision_from_arg,
        input flag_bits, input length_code, input end_consumed,
        output ready
    );
endinterface

>>> sv/fsp_cfg_if.sv
// ---------------------------------------------------------------------------
// fsp_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fsp_pkg::CFG_IDX_BITS-1:0]  index;
    logic                              wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> sv/printf_format_spec_parser.sv
// ---------------------------------------------------------------------------
// printf_format_spec_parser: one format character per cycle, sustained while no stall holds the step.
// Result: registered in the result register when the step takes its closing character.
// Input register -> parse step -> result register; spec state updates each step.
// Stalls: only a spec-closing character waits, while the result register still holds
// an untaken transaction; absorbed characters always go through.
// Reset: parse state cleared, float_en_reg and size_long_reg set to 1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "printf_format_spec_parser_assert.svh"

module printf_format_spec_parser #(
    parameter int unsigned COUNT_BITS    = fsp_pkg::COUNT_BITS_DEF,
    parameter int unsigned POINTER_BYTES = fsp_pkg::POINTER_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fsp_char_if.sink  chars,
    fsp_spec_if.source specs,
    fsp_cfg_if.sink   cfg
);

    // -----------------------------------------------------------------------
    // Configuration registers. The user is to issue writes only while idle; the
    // block does not enforce it. Writes take effect straight away with no interlock.
    // -----------------------------------------------------------------------
    logic float_en_reg;
    logic size_long_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            float_en_reg  <= 1'b1;
            size_long_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                fsp_pkg::CFG_FLOAT_EN:  float_en_reg  <= cfg.wdata;
                fsp_pkg::CFG_SIZE_LONG: size_long_reg <= cfg.wdata;
                default: ;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Input register: holds one character until the step consumes it.
    // -----------------------------------------------------------------------
    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_ch_reg;

    // -----------------------------------------------------------------------
    // Parse state
    // -----------------------------------------------------------------------
    fsp_pkg::fsp_state_t   st_reg;
    fsp_pkg::fsp_state_t   st_next;
    logic [COUNT_BITS-1:0] wcnt_reg;
    logic [COUNT_BITS-1:0] wcnt_next;
    logic [COUNT_BITS-1:0] pcnt_reg;
    logic [COUNT_BITS-1:0] pcnt_next;

    // -----------------------------------------------------------------------
    // Result register
    // -----------------------------------------------------------------------
    logic                 out_vld_reg;
    logic                 out_vld_next;
    fsp_pkg::fsp_result_t out_res_reg;

    logic                 step_emit;
    fsp_pkg::fsp_result_t step_res;
    logic                 advance;

    fsp_step #(
        .COUNT_BITS    (COUNT_BITS),
        .POINTER_BYTES (POINTER_BYTES)
    ) u_step (
        .ch        (in_ch_reg),
        .st        (st_reg),
        .wcnt      (wcnt_reg),
        .pcnt      (pcnt_reg),
        .float_en  (float_en_reg),
        .size_long (size_long_reg),
        .st_next   (st_next),
        .wcnt_next (wcnt_next),
        .pcnt_next (pcnt_next),
        .emit      (step_emit),
        .res       (step_res)
    );

    // The step only stalls when it closes a spec and the result register
    // still holds an untaken transaction. Characters that are absorbed
    // always go through.
    assign advance     = in_vld_reg && (!step_emit || !out_vld_reg || specs.ready);
    assign chars.ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (chars.valid && chars.ready)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance && step_emit)
            out_vld_next = 1'b1;
        else if (specs.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= '0;
            wcnt_reg    <= '0;
            pcnt_reg    <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                st_reg   <= st_next;
                wcnt_reg <= wcnt_next;
                pcnt_reg <= pcnt_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
            in_ch_reg <= chars.ch;
        if (advance && step_emit)
            out_res_reg <= step_res;
    end

    assign specs.valid              = out_vld_reg;
    assign specs.spec_kind          = out_res_reg.spec_kind;
    assign specs.radix              = out_res_reg.radix;
    assign specs.field_width        = out_res_reg.field_width;
    assign specs.digits_wanted      = out_res_reg.digits_wanted;
    assign specs.width_from_arg     = out_res_reg.width_from_arg;
    assign specs.precision_from_arg = out_res_reg.precision_from_arg;
    assign specs.flag_bits          = out_res_reg.flag_bits;
    assign specs.length_code        = out_res_reg.length_code;
    assign specs.end_consumed       = out_res_reg.end_consumed;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    // a held character means the result side is backed up
    `FSP_ASSERT_SAME(a_stall_cause, clk, rst_n, in_vld_reg && !advance,
        out_vld_reg && !specs.ready)
    // closing a spec leaves a clean parse state
    `FSP_ASSERT_NEXT(a_clear_after_spec, clk, rst_n, advance && step_emit,
        st_reg.phase == fsp_pkg::PH_FLAGS && wcnt_reg == '0 && pcnt_reg == '0)
    // an unconsumed end character only comes with kind none
    `FSP_ASSERT_SAME(a_unconsumed_none, clk, rst_n, out_vld_reg && !out_res_reg.end_consumed,
        out_res_reg.spec_kind == fsp_pkg::KIND_NONE)
    // radix is set for integer kinds only
    `FSP_ASSERT_SAME(a_radix_int_only, clk, rst_n,
        out_vld_reg && out_res_reg.radix != fsp_pkg::RADIX_NONE,
        out_res_reg.spec_kind == fsp_pkg::KIND_INT || out_res_reg.spec_kind == fsp_pkg::KIND_UINT)

endmodule

>>> sv/fsp_digit_acc.sv
// ---------------------------------------------------------------------------
// fsp_digit_acc
// Saturating decimal accumulate: cnt * 10 + digit, clamped to all ones.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsp_digit_acc #(
    parameter int unsigned COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0] cnt,
    input  logic [3:0]            digit,
    output logic [COUNT_BITS-1:0] acc
);

    localparam int unsigned WIDE = COUNT_BITS + 4;

    logic [WIDE-1:0] sum;

    // x*10 = x*8 + x*2
    assign sum = {1'b0, cnt, 3'b000} + {3'b000, cnt, 1'b0} + WIDE'(digit);
    assign acc = (sum[WIDE-1:COUNT_BITS] != 4'd0) ? {COUNT_BITS{1'b1}}
                                                  : sum[COUNT_BITS-1:0];

endmodule

>>> sv/fsp_step.sv
// ---------------------------------------------------------------------------
// fsp_step
// One parse step: phase decode, counter update and type rules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsp_step #(
    parameter int unsigned COUNT_BITS    = fsp_pkg::COUNT_BITS_DEF,
    parameter int unsigned POINTER_BYTES = fsp_pkg::POINTER_BYTES_DEF
) (
    input  logic [7:0]             ch,
    input  fsp_pkg::fsp_state_t    st,
    input  logic [COUNT_BITS-1:0]  wcnt,
    input  logic [COUNT_BITS-1:0]  pcnt,
    input  logic                   float_en,
    input  logic                   size_long,
    output fsp_pkg::fsp_state_t    st_next,
    output logic [COUNT_BITS-1:0]  wcnt_next,
    output logic [COUNT_BITS-1:0]  pcnt_next,
    output logic                   emit,
    output fsp_pkg::fsp_result_t   res
);

    localparam logic [COUNT_BITS-1:0] PTR_WIDTH = COUNT_BITS'(POINTER_BYTES * 2);

    logic [COUNT_BITS-1:0] wacc;
    logic [COUNT_BITS-1:0] pacc;
    logic                  is_dig;

    assign is_dig = (ch >= "0") && (ch <= "9");

    fsp_digit_acc #(.COUNT_BITS(COUNT_BITS)) u_wacc (
        .cnt   (wcnt),
        .digit (ch[3:0]),
        .acc   (wacc)
    );

    fsp_digit_acc #(.COUNT_BITS(COUNT_BITS)) u_pacc (
        .cnt   (pcnt),
        .digit (ch[3:0]),
        .acc   (pacc)
    );

    always_comb
    begin
        logic                  to_w;
        logic                  to_len;
        logic                  to_l;
        logic                  to_h;
        logic                  to_type;
        logic [7:0]            fl;
        logic [COUNT_BITS-1:0] wid;

        to_w      = 1'b0;
        to_len    = 1'b0;
        to_l      = 1'b0;
        to_h      = 1'b0;
        to_type   = 1'b0;
        fl        = st.flags;
        wid       = wcnt;
        st_next   = st;
        wcnt_next = wcnt;
        pcnt_next = pcnt;
        emit      = 1'b0;
        res       = '0;

        case (st.phase)
            fsp_pkg::PH_FLAGS, fsp_pkg::PH_UNUSED:
            begin
                st_next.phase = fsp_pkg::PH_FLAGS;
                if (ch == "0")
                    st_next.flags[fsp_pkg::FB_ZERO] = 1'b1;
                else if (ch == "-")
                    st_next.flags[fsp_pkg::FB_LEFT] = 1'b1;
                else if (ch == "+")
                    st_next.flags[fsp_pkg::FB_PLUS] = 1'b1;
                else if (ch == " ")
                    st_next.flags[fsp_pkg::FB_SPACE] = 1'b1;
                else if (ch == "#")
                    st_next.flags[fsp_pkg::FB_HASH] = 1'b1;
                else if (is_dig)
                begin
                    wcnt_next     = wacc;
                    st_next.phase = fsp_pkg::PH_WIDTH;
                end
                else if (ch == "*")
                begin
                    st_next.stars[0] = 1'b1;
                    st_next.phase    = fsp_pkg::PH_WIDTH;
                end
                else
                    to_w = 1'b1;
            end
            fsp_pkg::PH_WIDTH:      to_w = 1'b1;
            fsp_pkg::PH_PREC_START:
            begin
                if (is_dig)
                begin
                    pcnt_next     = pacc;
                    st_next.phase = fsp_pkg::PH_PREC_DIG;
                end
                else if (ch == "*")
                begin
                    st_next.stars[1] = 1'b1;
                    st_next.phase    = fsp_pkg::PH_PREC_DIG;
                end
                else
                    to_len = 1'b1;
            end
            fsp_pkg::PH_PREC_DIG:
            begin
                if (is_dig && !st.stars[1])
                    pcnt_next = pacc;
                else
                    to_len = 1'b1;
            end
            fsp_pkg::PH_AFTER_L:    to_l = 1'b1;
            fsp_pkg::PH_AFTER_H:    to_h = 1'b1;
            fsp_pkg::PH_TYPE:       to_type = 1'b1;
            default:                to_type = 1'b1;
        endcase

        if (to_w)
        begin
            if (is_dig && !st.stars[0])
            begin
                wcnt_next     = wacc;
                st_next.phase = fsp_pkg::PH_WIDTH;
            end
            else if (ch == ".")
            begin
                st_next.flags[fsp_pkg::FB_PREC] = 1'b1;
                st_next.phase = fsp_pkg::PH_PREC_START;
            end
            else
                to_len = 1'b1;
        end

        if (to_len)
        begin
            if (ch == "l")
            begin
                st_next.length = fsp_pkg::LEN_L;
                st_next.phase  = fsp_pkg::PH_AFTER_L;
            end
            else if (ch == "h")
            begin
                st_next.length = fsp_pkg::LEN_H;
                st_next.phase  = fsp_pkg::PH_AFTER_H;
            end
            else if (ch inside {"t", "j", "z"})
            begin
                st_next.length = size_long ? fsp_pkg::LEN_L : fsp_pkg::LEN_LLONLY;
                st_next.phase  = fsp_pkg::PH_TYPE;
            end
            else
                to_type = 1'b1;
        end

        if (to_l)
        begin
            if (ch == "l")
            begin
                st_next.length = fsp_pkg::LEN_LL;
                st_next.phase  = fsp_pkg::PH_TYPE;
            end
            else
                to_type = 1'b1;
        end

        if (to_h)
        begin
            if (ch == "h")
            begin
                st_next.length = fsp_pkg::LEN_HH;
                st_next.phase  = fsp_pkg::PH_TYPE;
            end
            else
                to_type = 1'b1;
        end

        // type character always closes the spec
        if (to_type)
        begin
            emit              = 1'b1;
            res.spec_kind     = fsp_pkg::KIND_NONE;
            res.radix         = fsp_pkg::RADIX_NONE;
            res.end_consumed  = 1'b1;

            if (ch inside {"d", "i", "u", "x", "X", "o", "b"})
            begin
                if (ch inside {"x", "X"})
                    res.radix = fsp_pkg::RADIX_HEX;
                else if (ch == "o")
                    res.radix = fsp_pkg::RADIX_OCT;
                else if (ch == "b")
                    res.radix = fsp_pkg::RADIX_BIN;
                else
                begin
                    res.radix = fsp_pkg::RADIX_DEC;
                    fl[fsp_pkg::FB_HASH] = 1'b0;
                end
                if (ch == "X")
                    fl[fsp_pkg::FB_UPPER] = 1'b1;
                if (!(ch inside {"d", "i"}))
                begin
                    fl[fsp_pkg::FB_PLUS]  = 1'b0;
                    fl[fsp_pkg::FB_SPACE] = 1'b0;
                end
                if (fl[fsp_pkg::FB_PREC])
                    fl[fsp_pkg::FB_ZERO] = 1'b0;
                res.spec_kind = (ch inside {"d", "i"}) ? fsp_pkg::KIND_INT
                                                       : fsp_pkg::KIND_UINT;
            end
            else if (ch inside {"f", "F"})
            begin
                if (float_en)
                begin
                    if (ch == "F")
                        fl[fsp_pkg::FB_UPPER] = 1'b1;
                    res.spec_kind = fsp_pkg::KIND_FLOAT;
                end
                else
                    res.end_consumed = 1'b0;
            end
            else if (ch inside {"e", "E", "g", "G"})
            begin
                if (float_en)
                begin
                    if (ch inside {"g", "G"})
                        fl[fsp_pkg::FB_ADAPT] = 1'b1;
                    if (ch inside {"E", "G"})
                        fl[fsp_pkg::FB_UPPER] = 1'b1;
                    res.spec_kind = fsp_pkg::KIND_EXP;
                end
                else
                    res.end_consumed = 1'b0;
            end
            else if (ch == "c")
                res.spec_kind = fsp_pkg::KIND_CHAR;
            else if (ch == "s")
                res.spec_kind = fsp_pkg::KIND_STR;
            else if (ch == "p")
            begin
                wid                   = PTR_WIDTH;
                fl[fsp_pkg::FB_ZERO]  = 1'b1;
                fl[fsp_pkg::FB_UPPER] = 1'b1;
                res.spec_kind         = fsp_pkg::KIND_PTR;
            end
            else if (ch == "%")
                res.spec_kind = fsp_pkg::KIND_PERCENT;
            else
                res.end_consumed = 1'b0;

            res.field_width        = 16'(wid);
            res.digits_wanted      = 16'(pcnt);
            res.width_from_arg     = st.stars[0];
            res.precision_from_arg = st.stars[1];
            res.flag_bits          = fl;
            res.length_code        = st.length;

            st_next       = '0;
            st_next.phase = fsp_pkg::PH_FLAGS;
            wcnt_next     = '0;
            pcnt_next     = '0;
        end
    end

endmodule
